>>> design/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types and codes for the LC-3b instruction executor.
// ----------------------------------------------------------------------------
package lc3_pkg;

	localparam int MEM_WORDS_DEF = 32768;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_EXEC = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LDB  = 4'h2;
	localparam logic [3:0] OP_STB  = 4'h3;
	localparam logic [3:0] OP_JSR  = 4'h4;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_LDW  = 4'h6;
	localparam logic [3:0] OP_STW  = 4'h7;
	localparam logic [3:0] OP_XOR  = 4'h9;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_SHF  = 4'hD;
	localparam logic [3:0] OP_LEA  = 4'hE;
	localparam logic [3:0] OP_TRAP = 4'hF;

	typedef struct packed {
		logic        we;
		logic        re;
		logic [14:0] addr;
		logic [15:0] wdata;
	} mem_req_t;

endpackage

>>> design/lc3_req_if.sv
// ----------------------------------------------------------------------------
// lc3_req_if
// Request channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface lc3_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [14:0] address;
	logic [15:0] data;
	logic [2:0]  reg_index;

	modport source (output valid, action, address, data, reg_index, input ready);
	modport sink (input valid, action, address, data, reg_index, output ready);
endinterface

>>> design/lc3_rsp_if.sv
// ----------------------------------------------------------------------------
// lc3_rsp_if
// Result channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface lc3_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] pc_out;
	logic        cond_n;
	logic        cond_z;
	logic        cond_p;
	logic [15:0] reg_value;
	logic [15:0] read_word;
	logic        halted;
	logic [31:0] instructions_done;

	modport source (output valid, pc_out, cond_n, cond_z, cond_p, reg_value, read_word,
		halted, instructions_done, input ready);
	modport sink (input valid, pc_out, cond_n, cond_z, cond_p, reg_value, read_word,
		halted, instructions_done, output ready);
endinterface

>>> design/lc3_mem.sv
// ----------------------------------------------------------------------------
// lc3_mem
// Single-port word memory, registered read, zero sweep after reset.
// ----------------------------------------------------------------------------
module lc3_mem #(
	parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lc3_pkg::mem_req_t req,
	output logic [15:0]       rdata,
	output logic              clearing
);
	localparam int AW = $clog2(MEM_WORDS);

	logic [15:0]   mem_q [MEM_WORDS];
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (req.we) begin
			mem_q[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.addr[AW-1:0]];
		end
	end

	assign clearing = clr_q;
endmodule

>>> design/lc3b_instruction_executor.sv
// ----------------------------------------------------------------------------
// lc3b_instruction_executor
// LC-3b core with its own word memory, driven one item at a time.
// ----------------------------------------------------------------------------
// Usage: each request item loads a memory word, executes one instruction, or
// reads a memory word; every item returns exactly one result item with the
// PC, condition codes, the selected register, the read word, halt and count.
// cfg_we/cfg_data write the start PC, which also loads the PC; write it idle.
// After accept, load, read and halted execute go through S_RES; ALU, branch,
// jump and STW end in S_DEC; LDB, LDW and TRAP go on to S_MEMRD, STB to S_STB.
// Every execute that is not halted costs one fetch through the single memory
// port, loads and traps a second read, STB a read and a write; a new item is
// accepted in the final cycle of the previous one unless that cycle writes
// memory.
// Reset: registers, flags and count clear, Z is set, PC is zero, and a sweep
// zeroes all MEM_WORDS memory words with req.ready low.
// A stalled result sits in the output register; the next item is still taken
// and waits in its last cycle until the output register frees.
// ----------------------------------------------------------------------------
module lc3b_instruction_executor #(
	parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lc3_req_if.sink     req,
	lc3_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_RES, S_DEC, S_MEMRD, S_STB} state_t;

	state_t            state_q, state_nx;
	lc3_pkg::mem_req_t mreq, creq;
	logic [15:0]       rdata;
	logic              clearing;

	logic [15:0] pc_q, pc_nx;
	logic        n_q, z_q, p_q, n_nx, z_nx, p_nx;
	logic [15:0] rf_q [8];
	logic [31:0] cnt_q;
	logic        halt_q;
	logic [1:0]  act_s1;
	logic [2:0]  ri_s1;
	logic [15:0] ir_s1, ea_q;

	logic        fin, pbusy, cnt_inc, rf_we, out_free, adv, accept, halt_set;
	logic [2:0]  rf_wa;
	logic [15:0] rf_wd;
	logic [15:0] ir, a, b, npc, r, eab, eaw, ea_sel, shf, lbyte;
	logic [3:0]  op;
	logic [2:0]  dr;
	logic        br_take;

	lc3_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(mreq), .rdata(rdata), .clearing(clearing)
	);

	assign ir  = (state_q == S_DEC) ? rdata : ir_s1;
	assign op  = ir[15:12];
	assign dr  = ir[11:9];
	assign a   = rf_q[ir[8:6]];
	assign b   = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_q[ir[2:0]];
	assign npc = pc_q + 16'd2;
	assign eab = a + {{10{ir[5]}}, ir[5:0]};
	assign eaw = a + {{9{ir[5]}}, ir[5:0], 1'b0};
	assign ea_sel = (op == lc3_pkg::OP_LDB || op == lc3_pkg::OP_STB) ? eab : eaw;
	assign br_take = (ir[11] & n_q) | (ir[10] & z_q) | (ir[9] & p_q);
	assign lbyte = ea_q[0] ? {{8{rdata[15]}}, rdata[15:8]} : {{8{rdata[7]}}, rdata[7:0]};

	always_comb begin
		if (!ir[4]) begin
			shf = a << ir[3:0];
		end else if (!ir[5]) begin
			shf = a >> ir[3:0];
		end else begin
			shf = 16'($signed(a) >>> ir[3:0]);
		end
		case (op)
			lc3_pkg::OP_ADD: r = a + b;
			lc3_pkg::OP_AND: r = a & b;
			lc3_pkg::OP_XOR: r = a ^ b;
			default:         r = shf;
		endcase
	end

	assign out_free = !rsp.valid || rsp.ready;

	always_comb begin
		state_nx = state_q;
		pc_nx    = pc_q;
		n_nx     = n_q;
		z_nx     = z_q;
		p_nx     = p_q;
		rf_we    = 1'b0;
		rf_wa    = dr;
		rf_wd    = r;
		cnt_inc  = 1'b0;
		fin      = 1'b0;
		pbusy    = 1'b0;
		creq     = '0;
		case (state_q)
			S_IDLE: begin
			end
			S_RES: begin
				fin      = 1'b1;
				state_nx = S_IDLE;
			end
			S_DEC: begin
				pc_nx    = npc;
				state_nx = S_IDLE;
				fin      = 1'b1;
				cnt_inc  = 1'b1;
				case (op)
					lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_XOR,
					lc3_pkg::OP_SHF: begin
						rf_we = 1'b1;
					end
					lc3_pkg::OP_BR: begin
						if (br_take) begin
							pc_nx = npc + {{6{ir[8]}}, ir[8:0], 1'b0};
						end
					end
					lc3_pkg::OP_JMP: begin
						pc_nx = a;
					end
					lc3_pkg::OP_JSR: begin
						pc_nx = ir[11] ? npc + {{4{ir[10]}}, ir[10:0], 1'b0} : a;
						rf_we = 1'b1;
						rf_wa = 3'd7;
						rf_wd = npc;
					end
					lc3_pkg::OP_LEA: begin
						rf_we = 1'b1;
						rf_wd = npc + {{6{ir[8]}}, ir[8:0], 1'b0};
					end
					lc3_pkg::OP_STW: begin
						pbusy      = 1'b1;
						creq.we    = 1'b1;
						creq.addr  = eaw[15:1];
						creq.wdata = rf_q[dr];
					end
					lc3_pkg::OP_LDB, lc3_pkg::OP_LDW, lc3_pkg::OP_STB: begin
						pc_nx     = pc_q;
						fin       = 1'b0;
						cnt_inc   = 1'b0;
						pbusy     = 1'b1;
						creq.re   = 1'b1;
						creq.addr = ea_sel[15:1];
						state_nx  = (op == lc3_pkg::OP_STB) ? S_STB : S_MEMRD;
					end
					lc3_pkg::OP_TRAP: begin
						pc_nx     = pc_q;
						fin       = 1'b0;
						cnt_inc   = 1'b0;
						pbusy     = 1'b1;
						creq.re   = 1'b1;
						creq.addr = {7'd0, ir[7:0]};
						state_nx  = S_MEMRD;
					end
					default: begin
					end
				endcase
				if (rf_we && rf_wa == dr && op != lc3_pkg::OP_LEA && op != lc3_pkg::OP_JSR) begin
					n_nx = r[15];
					z_nx = (r == 16'd0);
					p_nx = !r[15] && (r != 16'd0);
				end
			end
			S_MEMRD: begin
				fin      = 1'b1;
				cnt_inc  = 1'b1;
				state_nx = S_IDLE;
				pc_nx    = npc;
				rf_we    = 1'b1;
				if (op == lc3_pkg::OP_TRAP) begin
					pc_nx = rdata;
					rf_wa = 3'd7;
					rf_wd = npc;
				end else begin
					rf_wd = (op == lc3_pkg::OP_LDB) ? lbyte : rdata;
					n_nx  = rf_wd[15];
					z_nx  = (rf_wd == 16'd0);
					p_nx  = !rf_wd[15] && (rf_wd != 16'd0);
				end
			end
			S_STB: begin
				fin        = 1'b1;
				cnt_inc    = 1'b1;
				pbusy      = 1'b1;
				state_nx   = S_IDLE;
				pc_nx      = npc;
				creq.we    = 1'b1;
				creq.addr  = ea_q[15:1];
				creq.wdata = ea_q[0] ? {rf_q[dr][7:0], rdata[7:0]}
				                     : {rdata[15:8], rf_q[dr][7:0]};
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign adv = !fin || out_free;
	assign req.ready = !clearing &&
		(state_q == S_IDLE || (fin && out_free && !pbusy));
	assign accept = req.valid && req.ready;
	assign halt_set = accept && req.action == lc3_pkg::ACT_EXEC && !halt_q && pc_nx == 16'd0;

	always_comb begin
		mreq = adv ? creq : '0;
		if (accept) begin
			mreq = '0;
			case (req.action)
				lc3_pkg::ACT_LOAD: begin
					mreq.we    = 1'b1;
					mreq.addr  = req.address;
					mreq.wdata = req.data;
				end
				lc3_pkg::ACT_EXEC: begin
					mreq.re   = !halt_q && pc_nx != 16'd0;
					mreq.addr = pc_nx[15:1];
				end
				default: begin
					mreq.re   = 1'b1;
					mreq.addr = req.address;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pc_q          <= '0;
			n_q           <= 1'b0;
			z_q           <= 1'b1;
			p_q           <= 1'b0;
			cnt_q         <= '0;
			halt_q        <= 1'b0;
			rsp.valid     <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (fin && adv) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			if (adv) begin
				state_q <= state_nx;
				pc_q    <= pc_nx;
				n_q     <= n_nx;
				z_q     <= z_nx;
				p_q     <= p_nx;
				if (cnt_inc) begin
					cnt_q <= cnt_q + 32'd1;
				end
				if (rf_we) begin
					rf_q[rf_wa] <= rf_wd;
				end
			end
			if (accept) begin
				state_q <= (req.action == lc3_pkg::ACT_EXEC && !halt_q && pc_nx != 16'd0)
					? S_DEC : S_RES;
			end
			if (halt_set) begin
				halt_q <= 1'b1;
			end
			if (cfg_we) begin
				pc_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= req.action;
			ri_s1  <= req.reg_index;
		end
		if (state_q == S_DEC) begin
			ir_s1 <= rdata;
			ea_q  <= ea_sel;
		end
		if (fin && adv) begin
			rsp.pc_out            <= pc_nx;
			rsp.cond_n            <= n_nx;
			rsp.cond_z            <= z_nx;
			rsp.cond_p            <= p_nx;
			rsp.reg_value         <= (rf_we && rf_wa == ri_s1) ? rf_wd : rf_q[ri_s1];
			rsp.read_word         <= (state_q == S_RES && act_s1 != lc3_pkg::ACT_LOAD &&
				act_s1 != lc3_pkg::ACT_EXEC) ? rdata : 16'd0;
			rsp.halted            <= halt_q;
			rsp.instructions_done <= cnt_inc ? cnt_q + 32'd1 : cnt_q;
		end
	end
endmodule
